// ===== design/tagged_integer_alu_macros.svh =====
// Assertion macros for the tagged integer ALU.
// Included by tagged_integer_alu, which checks its own logic; no other dependencies.
`ifndef TAGGED_INTEGER_ALU_MACROS_SVH
`define TAGGED_INTEGER_ALU_MACROS_SVH
`ifndef SYNTHESIS
`define TIA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tagged_integer_alu: assertion failed");
`define TIA_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("tagged_integer_alu: forbidden condition seen");
`else
`define TIA_ASSERT(lbl, clk, rstn, prop)
`define TIA_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== design/tia_pkg.sv =====
// Types, codes and helper functions of the tagged integer ALU.
// Used by every module of the block; depends on nothing else.
package tia_pkg;

  localparam int unsigned NumCells = 32;

  typedef enum logic [2:0] {
    KIND_ADD   = 3'd0,
    KIND_SUB   = 3'd1,
    KIND_SLT   = 3'd2,
    KIND_XOR   = 3'd4,
    KIND_SHIFT = 3'd5,
    KIND_OR    = 3'd6,
    KIND_AND   = 3'd7
  } kind_e;

  localparam logic [6:0] VAR_MULDIV = 7'b0000001;
  localparam logic [6:0] VAR_SRL    = 7'b0100000;
  localparam logic [6:0] VAR_SLL    = 7'b0000000;

  localparam logic [2:0] TAG_UB = 3'd0;
  localparam logic [2:0] TAG_UH = 3'd1;
  localparam logic [2:0] TAG_UW = 3'd2;
  localparam logic [2:0] TAG_SB = 3'd3;
  localparam logic [2:0] TAG_SH = 3'd4;
  localparam logic [2:0] TAG_SW = 3'd5;

  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  variant;
    logic [31:0] first_data;
    logic [2:0]  first_tag;
    logic [31:0] second_data;
    logic [2:0]  second_tag;
    logic [4:0]  dest_index;
  } in_t;

  typedef struct packed {
    logic [31:0] result_data;
    logic [2:0]  result_tag;
    logic [4:0]  dest_out;
    logic        write_enable;
  } out_t;

  // One slot of the divider chain; non-divide results ride along in data.
  typedef struct packed {
    logic        is_div;
    logic        is_rem;
    logic        neg_quo;
    logic        neg_rem;
    logic [31:0] divisor;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] data;
    logic [2:0]  tag;
    logic        we;
    logic [4:0]  dest;
  } stage_t;

  function automatic logic [2:0] norm_tag(logic [2:0] t);
    return (t > TAG_SW) ? TAG_SW : t;
  endfunction

  function automatic logic [31:0] extend(logic [31:0] d, logic [2:0] t);
    logic [31:0] r;
    case (t)
      TAG_UB:  r = {24'd0, d[7:0]};
      TAG_SB:  r = {{24{d[7]}}, d[7:0]};
      TAG_UH:  r = {16'd0, d[15:0]};
      TAG_SH:  r = {{16{d[15]}}, d[15:0]};
      default: r = d;
    endcase
    return r;
  endfunction

endpackage

// ===== design/tia_prep.sv =====
// Decode and operand preparation stage: computes every non-divide result,
// the multiplier product and the divider start values. Uses tia_pkg.
module tia_prep (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  tia_pkg::in_t    in_i,
  output logic            valid_o,
  output tia_pkg::stage_t stage_o
);

  logic            valid_q;
  tia_pkg::stage_t stage_q, stage_d;

  logic [2:0]  ta, tb, wt;
  logic        ua, ub, uns, sx, sy, na, nb, lt;
  logic [31:0] a, b, x, y, shr;
  logic [4:0]  sh;
  logic signed [65:0] prod;

  always_comb begin
    a   = in_i.first_data;
    b   = in_i.second_data;
    ta  = tia_pkg::norm_tag(in_i.first_tag);
    tb  = tia_pkg::norm_tag(in_i.second_tag);
    ua  = (ta <= tia_pkg::TAG_UW);
    ub  = (tb <= tia_pkg::TAG_UW);
    wt  = (ta == tia_pkg::TAG_UW || tb == tia_pkg::TAG_UW) ? tia_pkg::TAG_UW : tia_pkg::TAG_SW;
    sh  = b[4:0];
    prod = $signed({~ua & a[31], a}) * $signed({~ub & b[31], b});
    shr = ua ? (a >> sh) : 32'($signed(a) >>> sh);

    na = a[31];
    nb = b[31];
    lt = (a < b);
    if (ua && ub)       lt = (a < b);
    else if (!ua && ub) lt = na || (a < b);
    else if (ua && !ub) lt = !nb && (a < b);
    else if (na != nb)  lt = na;

    // Divider operands: sign and magnitude; a zero divisor runs unsigned so
    // the chain yields all ones and the dividend as remainder.
    x   = tia_pkg::extend(a, ta);
    y   = tia_pkg::extend(b, tb);
    uns = (wt == tia_pkg::TAG_UW);
    sx  = !uns && (y != 32'd0) && x[31];
    sy  = !uns && y[31];

    stage_d         = '0;
    stage_d.divisor = sy ? (32'd0 - y) : y;
    stage_d.quo     = sx ? (32'd0 - x) : x;
    stage_d.rem     = 32'd0;
    stage_d.neg_quo = sx ^ sy;
    stage_d.neg_rem = sx;
    stage_d.dest    = in_i.dest_index;
    stage_d.we      = 1'b1;
    stage_d.tag     = wt;
    case (tia_pkg::kind_e'(in_i.kind))
      tia_pkg::KIND_ADD:
        stage_d.data = (in_i.variant == tia_pkg::VAR_MULDIV) ? prod[31:0] : a + b;
      tia_pkg::KIND_SUB:
        stage_d.data = (in_i.variant == tia_pkg::VAR_MULDIV) ? prod[63:32] : a - b;
      tia_pkg::KIND_SLT: begin
        stage_d.data = {31'd0, lt};
        stage_d.tag  = tia_pkg::TAG_UB;
      end
      tia_pkg::KIND_XOR: begin
        stage_d.data   = a ^ b;
        stage_d.is_div = (in_i.variant == tia_pkg::VAR_MULDIV);
      end
      tia_pkg::KIND_SHIFT: begin
        stage_d.tag = ta;
        if (in_i.variant == tia_pkg::VAR_SRL) begin
          stage_d.data = shr;
        end else if (in_i.variant == tia_pkg::VAR_SLL) begin
          stage_d.data = a << sh;
        end else begin
          stage_d.we  = 1'b0;
          stage_d.tag = 3'd0;
        end
      end
      tia_pkg::KIND_OR: begin
        stage_d.data   = a | b;
        stage_d.is_div = (in_i.variant == tia_pkg::VAR_MULDIV);
        stage_d.is_rem = stage_d.is_div;
      end
      tia_pkg::KIND_AND:
        stage_d.data = a & b;
      default: begin
        stage_d.we  = 1'b0;
        stage_d.tag = 3'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ===== design/tia_div_cell.sv =====
// One cell of the restoring divider chain: develops one quotient bit and
// hands the slot to the next cell. Uses tia_pkg.
module tia_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  tia_pkg::stage_t stage_i,
  output logic            valid_o,
  output tia_pkg::stage_t stage_o
);

  logic            valid_q;
  tia_pkg::stage_t stage_q, stage_d;
  logic [32:0]     shifted, diff;
  logic            fits;

  always_comb begin
    shifted = {stage_i.rem, stage_i.quo[31]};
    diff    = shifted - {1'b0, stage_i.divisor};
    fits    = !diff[32];
    stage_d = stage_i;
    stage_d.rem = fits ? diff[31:0] : shifted[31:0];
    stage_d.quo = {stage_i.quo[30:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ===== design/tagged_integer_alu.sv =====
// Tagged integer ALU: executes one register-register instruction per
// transaction on two tagged 32-bit operands.
// Input channel: in_valid_i / in_stall_o with payload in_data_i.
// Output channel: out_valid_o / out_stall_i with payload out_data_o.
// A transaction is taken at a clock edge where valid is high and stall low.
// Every operation goes through 34 registers: one decode stage that also
// holds the multiplier, 32 divider cells that each form one quotient bit,
// and the output register. The first is loaded at the edge that takes the
// transaction.
// Throughput is one transaction per cycle unless the pipeline is frozen.
// Every operation passes the whole cell chain so results leave in order.
// When the receiver stalls a held result, the whole pipeline freezes and
// in_stall_o rises; an empty output register never stalls the input.
// Reset (rst_ni low, asynchronous) empties all stages; no result is shown
// until a new transaction has passed through.
// Results for unknown codes carry write_enable low with data and tag zero.
// Depends on tia_pkg, tia_div_cell, tia_prep and tagged_integer_alu_macros.svh.
`include "tagged_integer_alu_macros.svh"
module tagged_integer_alu (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tia_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tia_pkg::out_t out_data_o
);

  localparam int unsigned N = tia_pkg::NumCells;

  logic            en;
  logic            valid_c [N+1];
  tia_pkg::stage_t stage_c [N+1];
  logic            out_valid_q;
  tia_pkg::out_t   out_q, out_d;
  tia_pkg::stage_t last;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  tia_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .in_i    (in_data_i),
    .valid_o (valid_c[0]),
    .stage_o (stage_c[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    tia_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_c[i]),
      .stage_i (stage_c[i]),
      .valid_o (valid_c[i+1]),
      .stage_o (stage_c[i+1])
    );
  end

  always_comb begin
    last = stage_c[N];
    out_d.result_tag   = last.tag;
    out_d.dest_out     = last.dest;
    out_d.write_enable = last.we;
    if (last.is_div && last.is_rem) begin
      out_d.result_data = last.neg_rem ? (32'd0 - last.rem) : last.rem;
    end else if (last.is_div) begin
      out_d.result_data = last.neg_quo ? (32'd0 - last.quo) : last.quo;
    end else begin
      out_d.result_data = last.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_c[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TIA_NEVER(a_unknown_clean, clk_i, rst_ni,
             out_valid_q && !out_q.write_enable &&
             (out_q.result_data != 32'd0 || out_q.result_tag != 3'd0))
  `TIA_NEVER(a_tag_range, clk_i, rst_ni,
             out_valid_q && out_q.result_tag > tia_pkg::TAG_SW)
  `TIA_ASSERT(a_chain_moves, clk_i, rst_ni,
              en && valid_c[N] |=> out_valid_q)
  `TIA_ASSERT(a_frozen_holds, clk_i, rst_ni,
              !en |=> $stable(valid_c[0]) && $stable(valid_c[N]))

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the tagged integer ALU: directed and random
// instructions, random idling on both channels, results compared in order.
// Depends on tia_pkg and the tagged_integer_alu module.
module testbench;
  import tia_pkg::*;

  class alu_scoreboard;
    out_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    static function logic [2:0] fix_tag(logic [2:0] t);
      return (t > TAG_SW) ? TAG_SW : t;
    endfunction

    static function logic [31:0] widen_by_tag(logic [31:0] d, logic [2:0] t);
      case (t)
        TAG_UB: return {24'd0, d[7:0]};
        TAG_SB: return {{24{d[7]}}, d[7:0]};
        TAG_UH: return {16'd0, d[15:0]};
        TAG_SH: return {{16{d[15]}}, d[15:0]};
        default: return d;
      endcase
    endfunction

    static function logic [31:0] divide(logic [31:0] a, logic [2:0] ta,
                                        logic [31:0] b, logic [2:0] tb, bit want_rem);
      logic [31:0] x, y, mx, my, r;
      bit uns;
      uns = (ta == TAG_UW) || (tb == TAG_UW);
      x = widen_by_tag(a, ta);
      y = widen_by_tag(b, tb);
      if (y == 0) return want_rem ? x : 32'hFFFF_FFFF;
      if (uns) return want_rem ? x % y : x / y;
      if (x == 32'h8000_0000 && y == 32'hFFFF_FFFF) return want_rem ? 32'd0 : 32'h8000_0000;
      mx = x[31] ? -x : x;
      my = y[31] ? -y : y;
      if (want_rem) begin
        r = mx % my;
        return x[31] ? -r : r;
      end
      r = mx / my;
      return (x[31] != y[31]) ? -r : r;
    endfunction

    static function out_t compute(in_t t);
      out_t o;
      logic [2:0] ta, tb, wt;
      logic [31:0] a, b;
      logic [63:0] pa, pb, p;
      bit ua, ub;
      ta = fix_tag(t.first_tag);
      tb = fix_tag(t.second_tag);
      a = t.first_data;
      b = t.second_data;
      ua = ta <= TAG_UW;
      ub = tb <= TAG_UW;
      wt = (ta == TAG_UW || tb == TAG_UW) ? TAG_UW : TAG_SW;
      o = '0;
      o.dest_out = t.dest_index;
      o.write_enable = 1'b1;
      o.result_tag = wt;
      case (t.kind)
        KIND_ADD: o.result_data = (t.variant == VAR_MULDIV) ? a * b : a + b;
        KIND_SUB: begin
          if (t.variant == VAR_MULDIV) begin
            pa = ua ? {32'd0, a} : {{32{a[31]}}, a};
            pb = ub ? {32'd0, b} : {{32{b[31]}}, b};
            p = pa * pb;
            o.result_data = p[63:32];
          end else o.result_data = a - b;
        end
        KIND_SLT: begin
          o.result_tag = TAG_UB;
          if (ua && ub) o.result_data = {31'd0, a < b};
          else if (!ua && ub) o.result_data = {31'd0, a[31] || a < b};
          else if (ua && !ub) o.result_data = {31'd0, !b[31] && a < b};
          else if (a[31] != b[31]) o.result_data = {31'd0, a[31]};
          else o.result_data = {31'd0, a < b};
        end
        KIND_XOR: o.result_data = (t.variant == VAR_MULDIV) ? divide(a, ta, b, tb, 0) : a ^ b;
        KIND_SHIFT: begin
          o.result_tag = ta;
          if (t.variant == VAR_SRL)
            o.result_data = (!ua && a[31]) ? ~((~a) >> b[4:0]) : a >> b[4:0];
          else if (t.variant == VAR_SLL) o.result_data = a << b[4:0];
          else begin
            o.result_tag = '0;
            o.write_enable = 1'b0;
          end
        end
        KIND_OR: o.result_data = (t.variant == VAR_MULDIV) ? divide(a, ta, b, tb, 1) : a | b;
        KIND_AND: o.result_data = a & b;
        default: begin
          o.result_tag = '0;
          o.write_enable = 1'b0;
        end
      endcase
      return o;
    endfunction

    function void note_instruction(in_t t);
      pending.push_back(compute(t));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.result_data !== want.result_data)
        $display("%0t: data expected %h actual %h", $time, want.result_data, got.result_data);
      if (got.result_tag !== want.result_tag)
        $display("%0t: tag expected %0d actual %0d", $time, want.result_tag, got.result_tag);
      if (got.dest_out !== want.dest_out)
        $display("%0t: dest expected %0d actual %0d", $time, want.dest_out, got.dest_out);
      if (got.write_enable !== want.write_enable)
        $display("%0t: we expected %b actual %b", $time, want.write_enable, got.write_enable);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  alu_scoreboard board = new();
  bit quiet_phase = 0;
  bit hold_phase = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  tagged_integer_alu u_dut (.*);

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom_range(0, 300);
      4: return 32'hFFFF_FF00 | $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t random_instruction();
    in_t t;
    t.kind = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: t.variant = VAR_MULDIV;
      4, 5: t.variant = VAR_SRL;
      6, 7: t.variant = VAR_SLL;
      default: t.variant = 7'($urandom_range(0, 127));
    endcase
    t.first_data = pick_word();
    t.second_data = pick_word();
    t.first_tag = 3'($urandom_range(0, 7));
    t.second_tag = 3'($urandom_range(0, 7));
    t.dest_index = 5'($urandom_range(0, 31));
    return t;
  endfunction

  // Valid drops for random idle cycles before each transaction, except in the quiet phase.
  task automatic send(in_t t);
    while (!quiet_phase && $urandom_range(0, 99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_instruction(t);
  endtask

  task automatic directed(logic [2:0] k, logic [6:0] v, logic [31:0] a, logic [2:0] ta,
                          logic [31:0] b, logic [2:0] tb);
    in_t t;
    t = '{k, v, a, ta, b, tb, 5'($urandom_range(0, 31))};
    send(t);
  endtask

  // Receiver: random stalls, plus one long hold while the sender keeps pushing.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
  end

  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_phase) begin
        out_stall_i <= 1'b1;
        for (n = 0; n < 120; n++) @(posedge clk_i);
        hold_phase = 0;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= (!quiet_phase && $urandom_range(0, 99) < 23);
      end
    end
  end

  initial begin
    int i, w;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed(KIND_ADD, 7'd0, 32'hFFFF_FFFF, TAG_UW, 32'd1, TAG_SB);
    directed(KIND_ADD, VAR_MULDIV, 32'h8000_0000, TAG_SW, 32'hFFFF_FFFF, TAG_SW);
    directed(KIND_SUB, 7'd5, 32'd0, TAG_UB, 32'd1, TAG_SH);
    directed(KIND_SUB, VAR_MULDIV, 32'hFFFF_FFFF, TAG_SW, 32'hFFFF_FFFF, TAG_UW);
    directed(KIND_SUB, VAR_MULDIV, 32'h8000_0000, TAG_SW, 32'h8000_0000, TAG_SW);
    directed(KIND_SLT, 7'd127, 32'hFFFF_FFFF, TAG_SW, 32'd1, TAG_UW);
    directed(KIND_SLT, 7'd0, 32'd1, TAG_UB, 32'h8000_0000, TAG_SH);
    directed(3'd3, 7'd0, 32'd5, TAG_UW, 32'd6, TAG_UW);
    directed(KIND_XOR, 7'd9, 32'hA5A5_A5A5, TAG_UH, 32'h5A5A_5A5A, TAG_SW);
    directed(KIND_XOR, VAR_MULDIV, 32'd7, TAG_SW, 32'd0, TAG_SW);
    directed(KIND_XOR, VAR_MULDIV, 32'h8000_0000, TAG_SW, 32'hFFFF_FFFF, TAG_SW);
    directed(KIND_XOR, VAR_MULDIV, 32'h0000_0080, TAG_SB, 32'h0000_FF03, TAG_SH);
    directed(KIND_XOR, VAR_MULDIV, 32'hFFFF_FFF9, TAG_UW, 32'd2, TAG_SW);
    directed(KIND_OR, VAR_MULDIV, 32'd7, TAG_UB, 32'h100, TAG_UB);
    directed(KIND_OR, VAR_MULDIV, 32'h8000_0000, TAG_SW, 32'hFFFF_FFFF, 3'd7);
    directed(KIND_OR, VAR_MULDIV, 32'hFFFF_FFF9, TAG_SW, 32'd2, TAG_SW);
    directed(KIND_OR, 7'd2, 32'hF0, TAG_UB, 32'h0F, TAG_UB);
    directed(KIND_SHIFT, VAR_SRL, 32'h8000_0000, TAG_SW, 32'd31, TAG_UB);
    directed(KIND_SHIFT, VAR_SRL, 32'h8000_0000, 3'd6, 32'hFFFF_FFE4, TAG_UB);
    directed(KIND_SHIFT, VAR_SRL, 32'h8000_0000, TAG_UW, 32'd4, TAG_UB);
    directed(KIND_SHIFT, VAR_SLL, 32'hFFFF_FFFF, TAG_SH, 32'd31, TAG_UB);
    directed(KIND_SHIFT, 7'd33, 32'd1, TAG_SW, 32'd1, TAG_SW);
    directed(KIND_AND, 7'd127, 32'hFFFF_FFFF, TAG_SB, 32'h1234_5678, 3'd7);
    for (i = 0; i < 850; i++) begin
      if (i == 200) hold_phase = 1;
      if (i == 400) begin
        in_valid_i <= 1'b0;
        w = 0;
        while (board.pending.size() != 0 && w < 5000) begin
          @(posedge clk_i);
          w++;
        end
      end
      quiet_phase = (i >= 550 && i < 700);
      send(random_instruction());
    end
    in_valid_i <= 1'b0;
    quiet_phase = 0;
    w = 0;
    while (board.pending.size() != 0 && w < 20000) begin
      @(posedge clk_i);
      w++;
    end
    repeat (40) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #200000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
